[rtl/fpacer_pkg.sv]
// Shared constants, types and command/status structs of the frame pacer.
package fpacer_pkg;

    // Canonical time base and update bound.
    localparam int TICKS_PER_SECOND = 10000000;
    localparam int MAX_UPDATES      = 63;

    // Field widths.
    localparam int TIME_W    = 64;
    localparam int ELAPSED_W = 40;
    localparam int FREQ_W    = 32;
    localparam int TARGET_W  = 24;
    localparam int COUNT_W   = 32;

    // Scaling multiplier: the clamped delta is multiplied in two halves.
    localparam int HALF_W = ELAPSED_W / 2;
    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int PART_W = HALF_W + TPS_W;
    localparam int PROD_W = ELAPSED_W + TPS_W;

    // Deltas closer than this to the target snap onto it.
    localparam int SNAP_WINDOW = TICKS_PER_SECOND / 4000;

    localparam int UPD_CNT_W = $clog2(MAX_UPDATES + 1);

    // Shared bit-serial divider.
    localparam int DIV_W     = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Configuration port and register indexes.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_FREQ  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_STEP = CFG_IDX_W'(3);

    localparam logic [FREQ_W-1:0]    FREQ_RESET      = FREQ_W'(1000000000);
    localparam logic [ELAPSED_W-1:0] MAX_DELTA_RESET = ELAPSED_W'(100000000);
    localparam logic [TARGET_W-1:0]  TARGET_RESET    = TARGET_W'(166667);

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE_START,
        ST_SCALE_RUN,
        ST_ADJUST,
        ST_UPDATE,
        ST_RATE,
        ST_MOD_RUN,
        ST_STATUS
    } fp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_tick;
        logic take_reset;
        logic mul_lo;
        logic mul_hi;
        logic div_scale;
        logic scale_sat;
        logic scale_done;
        logic adjust;
        logic step;
        logic rate;
        logic mod_start;
        logic mod_done;
        logic status;
    } fp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scale_over;
        logic div_busy;
        logic more_steps;
        logic out_free;
        logic rate_due;
    } fp_stat_t;

endpackage

[rtl/fixed_timestep_frame_pacer.sv]
// Top level of the fixed timestep frame pacer: controller, datapath and checks.
// A reset request passes from the idle state to the status state, which loads its status item
// into the output register once that register is free. A tick passes through the two multiply
// states, the bit-serial scaling divide, the adjust state, one update step for each update item,
// the rate state and the status state; a tick whose scaled delta saturates skips the divide, and
// a tick that closes a measurement second adds a remainder division. Output stalls hold the flow.
// rst_n clears all timing state and loads the configuration registers with their defaults.
module fixed_timestep_frame_pacer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [fpacer_pkg::TIME_W-1:0]     timer_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              is_update,
    output logic [fpacer_pkg::ELAPSED_W-1:0]  step_ticks,
    output logic [fpacer_pkg::TIME_W-1:0]     total_ticks,
    output logic [fpacer_pkg::COUNT_W-1:0]    frame_number,
    output logic [fpacer_pkg::COUNT_W-1:0]    frames_per_second,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpacer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpacer_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fpacer_pkg::*;

    fp_cmd_t  ctrl_cmd;
    fp_stat_t dp_stat;

    // Configuration writes complete at once.
    assign cfg_ready = 1'b1;

    fpacer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .stat     (dp_stat),
        .in_ready (in_ready),
        .cmd      (ctrl_cmd)
    );

    fpacer_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (ctrl_cmd),
        .stat              (dp_stat),
        .timer_value       (timer_value),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .is_update         (is_update),
        .step_ticks        (step_ticks),
        .total_ticks       (total_ticks),
        .frame_number      (frame_number),
        .frames_per_second (frames_per_second),
        .last              (last)
    );

    // A pending item is never overwritten by a new update or status item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.step || ctrl_cmd.status) |-> dp_stat.out_free)
        else $error("output register loaded while an item is still pending");

    // Every item presented is either an update or the closing status, never both.
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last != is_update))
        else $error("last flag does not match the item kind");

    // A tick keeps the input closed while it is being worked on.
    a_tick_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !req_type) |=> !in_ready)
        else $error("input accepted again right after a tick");

    // The shared divider is only launched when it is free.
    a_div_free_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.div_scale || ctrl_cmd.mod_start) |-> !dp_stat.div_busy)
        else $error("divider started while busy");

endmodule

[rtl/fpacer_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle, shared by scaling and rate window.
module fpacer_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [fpacer_pkg::FREQ_W-1:0]    divisor,
    input  logic [fpacer_pkg::FREQ_W-1:0]    init_rem,
    input  logic [fpacer_pkg::DIV_W-1:0]     init_shift,
    input  logic [fpacer_pkg::DIV_CNT_W-1:0] steps,
    output logic                             busy,
    output logic [fpacer_pkg::DIV_W-1:0]     shift_out,
    output logic [fpacer_pkg::FREQ_W-1:0]    rem_out
);
    import fpacer_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [FREQ_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     shift_reg, shift_next;

    logic [FREQ_W:0] trial;
    logic [FREQ_W:0] diff;
    logic            fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, shift_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = steps;
            rem_next   = init_rem;
            shift_next = init_shift;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            shift_next = {shift_reg[DIV_W-2:0], fits};
            count_next = count_reg - DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign busy      = busy_reg;
    assign shift_out = shift_reg;
    assign rem_out   = rem_reg;

endmodule

[rtl/fpacer_dp.sv]
// Datapath of the frame pacer: configuration, timing state, scaling and the output register.
module fpacer_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fpacer_pkg::fp_cmd_t               cmd,
    output fpacer_pkg::fp_stat_t              stat,
    input  logic [fpacer_pkg::TIME_W-1:0]     timer_value,
    input  logic                              cfg_valid,
    input  logic [fpacer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpacer_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              is_update,
    output logic [fpacer_pkg::ELAPSED_W-1:0]  step_ticks,
    output logic [fpacer_pkg::TIME_W-1:0]     total_ticks,
    output logic [fpacer_pkg::COUNT_W-1:0]    frame_number,
    output logic [fpacer_pkg::COUNT_W-1:0]    frames_per_second,
    output logic                              last
);
    import fpacer_pkg::*;

    localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);

    // Configuration registers.
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic [ELAPSED_W-1:0] max_delta_reg, max_delta_next;
    logic                 fixed_mode_reg, fixed_mode_next;
    logic [TARGET_W-1:0]  target_reg, target_next;

    // Timing state.
    logic [TIME_W-1:0]    last_time_reg, last_time_next;
    logic [TIME_W-1:0]    leftover_reg, leftover_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]    total_reg, total_next;
    logic [COUNT_W-1:0]   frame_reg, frame_next;
    logic [COUNT_W-1:0]   rate_reg, rate_next;
    logic [COUNT_W-1:0]   fis_reg, fis_next;
    logic [TIME_W-1:0]    sec_acc_reg, sec_acc_next;
    logic [UPD_CNT_W-1:0] upd_cnt_reg, upd_cnt_next;

    // Working registers.
    logic [ELAPSED_W-1:0] raw_reg, raw_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [ELAPSED_W-1:0] delta_reg, delta_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic                 o_upd_reg, o_upd_next;
    logic [ELAPSED_W-1:0] o_step_reg, o_step_next;
    logic [TIME_W-1:0]    o_total_reg, o_total_next;
    logic [COUNT_W-1:0]   o_frame_reg, o_frame_next;
    logic [COUNT_W-1:0]   o_rate_reg, o_rate_next;
    logic                 o_last_reg, o_last_next;

    logic [FREQ_W-1:0]    f_eff;
    logic [TIME_W-1:0]    raw_diff;
    logic [ELAPSED_W-1:0] raw_clamp;
    logic [HALF_W-1:0]    mul_in;
    logic [PART_W-1:0]    part_prod;
    logic [PROD_W-1:0]    prod_high;
    logic [ELAPSED_W-1:0] t_ext;
    logic [ELAPSED_W-1:0] snap_diff;
    logic [ELAPSED_W-1:0] snapped;
    logic [TIME_W:0]      left_sum;
    logic [TIME_W-1:0]    left_sat;
    logic [ELAPSED_W-1:0] step_amt;
    logic [TIME_W-1:0]    total_step;
    logic [COUNT_W-1:0]   frame_step;
    logic [COUNT_W-1:0]   fis_inc;
    logic                 out_free;
    logic                 mod_short;

    logic                 div_start;
    logic [FREQ_W-1:0]    div_init_rem;
    logic [DIV_W-1:0]     div_init_shift;
    logic [DIV_CNT_W-1:0] div_steps;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_shift;
    logic [FREQ_W-1:0]    div_rem;

    // A zero frequency counts as one.
    assign f_eff = (freq_reg == '0) ? FREQ_W'(1) : freq_reg;

    // Raw delta since the previous reading, clamped.
    assign raw_diff  = timer_value - last_time_reg;
    assign raw_clamp = (raw_diff > TIME_W'(max_delta_reg)) ? max_delta_reg
                                                           : raw_diff[ELAPSED_W-1:0];

    // One shared multiplier works on the low half, then the high half.
    assign mul_in    = cmd.mul_hi ? raw_reg[ELAPSED_W-1:HALF_W] : raw_reg[HALF_W-1:0];
    assign part_prod = mul_in * TPS_C;

    // Quotient would not fit in the elapsed width when the top part reaches the divisor.
    assign prod_high = prod_reg >> ELAPSED_W;

    // Snap to the target and add into the leftover with saturation.
    assign t_ext     = ELAPSED_W'(target_reg);
    assign snap_diff = (delta_reg > t_ext) ? (delta_reg - t_ext) : (t_ext - delta_reg);
    assign snapped   = (snap_diff < ELAPSED_W'(SNAP_WINDOW)) ? t_ext : delta_reg;
    assign left_sum  = {1'b0, leftover_reg} + (TIME_W + 1)'(snapped);
    assign left_sat  = left_sum[TIME_W] ? '1 : left_sum[TIME_W-1:0];

    // Values after one update step.
    assign step_amt   = fixed_mode_reg ? t_ext : delta_reg;
    assign total_step = total_reg + TIME_W'(step_amt);
    assign frame_step = frame_reg + COUNT_W'(1);
    assign fis_inc    = (upd_cnt_reg != '0) ? (fis_reg + COUNT_W'(1)) : fis_reg;

    assign out_free = !out_valid_reg || out_ready;

    // Divider operands: scaling, or the rate window remainder.
    assign mod_short = (sec_acc_reg[TIME_W-1:FREQ_W] < f_eff);
    assign div_start = cmd.div_scale || cmd.mod_start;

    always_comb
    begin
        if (cmd.mod_start)
        begin
            div_init_rem   = mod_short ? sec_acc_reg[TIME_W-1:FREQ_W] : '0;
            div_init_shift = mod_short ? (sec_acc_reg << FREQ_W) : sec_acc_reg;
            div_steps      = mod_short ? DIV_CNT_W'(FREQ_W) : DIV_CNT_W'(DIV_W);
        end
        else
        begin
            div_init_rem   = FREQ_W'(prod_high);
            div_init_shift = DIV_W'(prod_reg[ELAPSED_W-1:0]) << (DIV_W - ELAPSED_W);
            div_steps      = DIV_CNT_W'(ELAPSED_W);
        end
    end

    fpacer_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .divisor    (f_eff),
        .init_rem   (div_init_rem),
        .init_shift (div_init_shift),
        .steps      (div_steps),
        .busy       (div_busy),
        .shift_out  (div_shift),
        .rem_out    (div_rem)
    );

    // Status to the controller.
    always_comb
    begin
        stat.scale_over = (prod_high >= PROD_W'(f_eff));
        stat.div_busy   = div_busy;
        stat.more_steps = fixed_mode_reg
            ? ((leftover_reg >= TIME_W'(target_reg)) &&
               (upd_cnt_reg < UPD_CNT_W'(MAX_UPDATES)))
            : (upd_cnt_reg == '0);
        stat.out_free   = out_free;
        stat.rate_due   = (sec_acc_reg >= TIME_W'(f_eff));
    end

    // Configuration writes.
    always_comb
    begin
        freq_next       = freq_reg;
        max_delta_next  = max_delta_reg;
        fixed_mode_next = fixed_mode_reg;
        target_next     = target_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMER_FREQ:  freq_next       = cfg_data[FREQ_W-1:0];
                REG_MAX_DELTA:   max_delta_next  = cfg_data[ELAPSED_W-1:0];
                REG_FIXED_MODE:  fixed_mode_next = cfg_data[0];
                REG_TARGET_STEP: target_next     = cfg_data[TARGET_W-1:0];
                default:         freq_next       = freq_reg;
            endcase
        end
    end

    // Timing state updates per command.
    always_comb
    begin
        last_time_next = last_time_reg;
        leftover_next  = leftover_reg;
        elapsed_next   = elapsed_reg;
        total_next     = total_reg;
        frame_next     = frame_reg;
        rate_next      = rate_reg;
        fis_next       = fis_reg;
        sec_acc_next   = sec_acc_reg;
        upd_cnt_next   = upd_cnt_reg;
        if (cmd.take_reset)
        begin
            last_time_next = timer_value;
            leftover_next  = '0;
            rate_next      = '0;
            fis_next       = '0;
            sec_acc_next   = '0;
            upd_cnt_next   = '0;
        end
        if (cmd.take_tick)
        begin
            last_time_next = timer_value;
            sec_acc_next   = sec_acc_reg + raw_diff;
            upd_cnt_next   = '0;
        end
        if (cmd.adjust)
        begin
            leftover_next = fixed_mode_reg ? left_sat : '0;
        end
        if (cmd.step)
        begin
            elapsed_next = step_amt;
            total_next   = total_step;
            frame_next   = frame_step;
            upd_cnt_next = upd_cnt_reg + UPD_CNT_W'(1);
            if (fixed_mode_reg)
            begin
                leftover_next = leftover_reg - TIME_W'(target_reg);
            end
        end
        if (cmd.rate)
        begin
            if (stat.rate_due)
            begin
                rate_next = fis_inc;
                fis_next  = '0;
            end
            else
            begin
                fis_next = fis_inc;
            end
        end
        if (cmd.mod_done)
        begin
            sec_acc_next = TIME_W'(div_rem);
        end
    end

    // Working registers: clamped delta, product and scaled delta.
    always_comb
    begin
        raw_next   = cmd.take_tick ? raw_clamp : raw_reg;
        prod_next  = prod_reg;
        delta_next = delta_reg;
        if (cmd.mul_lo)
        begin
            prod_next = PROD_W'(part_prod);
        end
        if (cmd.mul_hi)
        begin
            prod_next = prod_reg + (PROD_W'(part_prod) << HALF_W);
        end
        if (cmd.scale_sat)
        begin
            delta_next = '1;
        end
        if (cmd.scale_done)
        begin
            delta_next = div_shift[ELAPSED_W-1:0];
        end
    end

    // Output register: an update item or the closing status item.
    always_comb
    begin
        o_upd_next   = o_upd_reg;
        o_step_next  = o_step_reg;
        o_total_next = o_total_reg;
        o_frame_next = o_frame_reg;
        o_rate_next  = o_rate_reg;
        o_last_next  = o_last_reg;
        if (cmd.step)
        begin
            o_upd_next   = 1'b1;
            o_step_next  = step_amt;
            o_total_next = total_step;
            o_frame_next = frame_step;
            o_rate_next  = rate_reg;
            o_last_next  = 1'b0;
        end
        else if (cmd.status)
        begin
            o_upd_next   = 1'b0;
            o_step_next  = elapsed_reg;
            o_total_next = total_reg;
            o_frame_next = frame_reg;
            o_rate_next  = rate_reg;
            o_last_next  = 1'b1;
        end
        if (cmd.step || cmd.status)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        end
    end

    // Registers with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg       <= FREQ_RESET;
            max_delta_reg  <= MAX_DELTA_RESET;
            fixed_mode_reg <= 1'b0;
            target_reg     <= TARGET_RESET;
            last_time_reg  <= '0;
            leftover_reg   <= '0;
            elapsed_reg    <= '0;
            total_reg      <= '0;
            frame_reg      <= '0;
            rate_reg       <= '0;
            fis_reg        <= '0;
            sec_acc_reg    <= '0;
            upd_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            freq_reg       <= freq_next;
            max_delta_reg  <= max_delta_next;
            fixed_mode_reg <= fixed_mode_next;
            target_reg     <= target_next;
            last_time_reg  <= last_time_next;
            leftover_reg   <= leftover_next;
            elapsed_reg    <= elapsed_next;
            total_reg      <= total_next;
            frame_reg      <= frame_next;
            rate_reg       <= rate_next;
            fis_reg        <= fis_next;
            sec_acc_reg    <= sec_acc_next;
            upd_cnt_reg    <= upd_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        raw_reg     <= raw_next;
        prod_reg    <= prod_next;
        delta_reg   <= delta_next;
        o_upd_reg   <= o_upd_next;
        o_step_reg  <= o_step_next;
        o_total_reg <= o_total_next;
        o_frame_reg <= o_frame_next;
        o_rate_reg  <= o_rate_next;
        o_last_reg  <= o_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign is_update         = o_upd_reg;
    assign step_ticks        = o_step_reg;
    assign total_ticks       = o_total_reg;
    assign frame_number      = o_frame_reg;
    assign frames_per_second = o_rate_reg;
    assign last              = o_last_reg;

endmodule

[rtl/fpacer_ctrl.sv]
// Controller state machine that sequences one item through the pacer datapath.
module fpacer_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  req_type,
    input  fpacer_pkg::fp_stat_t  stat,
    output logic                  in_ready,
    output fpacer_pkg::fp_cmd_t   cmd
);
    import fpacer_pkg::*;

    fp_state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = req_type ? ST_STATUS : ST_MUL_LO;
                end
            end
            ST_MUL_LO:      state_next = ST_MUL_HI;
            ST_MUL_HI:      state_next = ST_SCALE_START;
            ST_SCALE_START: state_next = stat.scale_over ? ST_ADJUST : ST_SCALE_RUN;
            ST_SCALE_RUN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_ADJUST;
                end
            end
            ST_ADJUST:      state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (!stat.more_steps)
                begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:        state_next = stat.rate_due ? ST_MOD_RUN : ST_STATUS;
            ST_MOD_RUN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.take_tick  = in_valid && !req_type;
                cmd.take_reset = in_valid && req_type;
            end
            ST_MUL_LO:      cmd.mul_lo = 1'b1;
            ST_MUL_HI:      cmd.mul_hi = 1'b1;
            ST_SCALE_START:
            begin
                cmd.scale_sat = stat.scale_over;
                cmd.div_scale = !stat.scale_over;
            end
            ST_SCALE_RUN:   cmd.scale_done = !stat.div_busy;
            ST_ADJUST:      cmd.adjust = 1'b1;
            ST_UPDATE:      cmd.step = stat.more_steps && stat.out_free;
            ST_RATE:
            begin
                cmd.rate      = 1'b1;
                cmd.mod_start = stat.rate_due;
            end
            ST_MOD_RUN:     cmd.mod_done = !stat.div_busy;
            ST_STATUS:      cmd.status = stat.out_free;
            default:        cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
